@@ design/subarray_xor_below_limit_counter_top_assert.svh @@
// ----------------------------------------------------------------------------
// assertion macros for the subarray xor counter
// concurrent checks on the rising clock, held off while reset is asserted
// ----------------------------------------------------------------------------
`ifndef SUBARRAY_XOR_BELOW_LIMIT_COUNTER_TOP_ASSERT_SVH
`define SUBARRAY_XOR_BELOW_LIMIT_COUNTER_TOP_ASSERT_SVH

// same-cycle implication
`define SXBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SXBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sxbl_pkg.sv @@
// ----------------------------------------------------------------------------
// sxbl_pkg
// shared widths and the command / status bundles between controller and
// datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sxbl_pkg;

  localparam int unsigned ELEM_W    = 20;
  localparam int unsigned LIMIT_W   = 20;
  localparam int unsigned CNT_OUT_W = 11;
  localparam int unsigned TOTAL_W   = 20;

  typedef struct packed {
    logic init_root;
    logic accept;
    logic clear_seq;
    logic ins_begin;
    logic ins_fresh;
    logic ins_load;
    logic ins_walk;
    logic ins_wb;
    logic pfx;
    logic q_begin;
    logic q_chk;
    logic q_cnt;
    logic tot;
    logic load_out;
  } sxbl_cmd_t;

  typedef struct packed {
    logic ins_blocked;
    logic ins_exists;
    logic walk_done;
    logic lvl_zero;
    logic limit_hi;
    logic q_need_cnt;
    logic qchk_stop;
    logic qcnt_stop;
    logic out_free;
  } sxbl_sts_t;

endpackage

@@ design/subarray_xor_below_limit_counter_top.sv @@
// ----------------------------------------------------------------------------
// subarray_xor_below_limit_counter_top
// counts subarrays ending at each element whose xor is below a limit, using a
// binary trie of prefix xors held in a node memory
// ----------------------------------------------------------------------------
//  channel | direction | signals                                  | handshake
//  in      | input     | element_value_i, start_sequence_i        | in_valid_i / in_ready_o
//  out     | output    | ending_here_count_o, running_total_o,    | out_valid_o / out_ready_i
//          |           | trie_full_o                              |
//  cfg     | input     | xor_limit_i                              | cfg_valid_i / cfg_ready_o
//
// one item at a time: a query walk of the trie, the total update and then an
// insert walk of the new prefix; a start first clears and inserts prefix zero
// after reset the empty root is written before the first item is taken
// a result waits in the output register while the next item is accepted;
// the block stalls before its next result only if that one is still untaken
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module subarray_xor_below_limit_counter_top
  import sxbl_pkg::*;
#(
  parameter int unsigned KEY_BITS   = 20,
  parameter int unsigned NODE_DEPTH = 32768,
  parameter int unsigned MAX_ITEMS  = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ELEM_W-1:0]    element_value_i,
  input  logic                 start_sequence_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CNT_OUT_W-1:0] ending_here_count_o,
  output logic [TOTAL_W-1:0]   running_total_o,
  output logic                 trie_full_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LIMIT_W-1:0]   xor_limit_i
);

  sxbl_cmd_t cmd;
  sxbl_sts_t sts;

  // the limit register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  sxbl_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .start_sequence_i (start_sequence_i),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  sxbl_dp #(
    .KEY_BITS   (KEY_BITS),
    .NODE_DEPTH (NODE_DEPTH),
    .MAX_ITEMS  (MAX_ITEMS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .xor_limit_i         (xor_limit_i),
    .element_value_i     (element_value_i),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .ending_here_count_o (ending_here_count_o),
    .running_total_o     (running_total_o),
    .trie_full_o         (trie_full_o),
    .cmd_i               (cmd),
    .sts_o               (sts)
  );

endmodule

@@ design/sxbl_ctrl.sv @@
// ----------------------------------------------------------------------------
// sxbl_ctrl
// sequencer: start clearing, query walk, total update, insert walk and
// result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sxbl_ctrl
  import sxbl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      start_sequence_i,
  input  sxbl_sts_t sts_i,
  output sxbl_cmd_t cmd_o
);

  typedef enum logic [12:0] {
    ST_INIT  = 13'b0000000000001,
    ST_IDLE  = 13'b0000000000010,
    ST_CLR   = 13'b0000000000100,
    ST_ICHK  = 13'b0000000001000,
    ST_ILOAD = 13'b0000000010000,
    ST_IWALK = 13'b0000000100000,
    ST_IWB   = 13'b0000001000000,
    ST_PFX   = 13'b0000010000000,
    ST_QBEG  = 13'b0000100000000,
    ST_QCHK  = 13'b0001000000000,
    ST_QCNT  = 13'b0010000000000,
    ST_TOT   = 13'b0100000000000,
    ST_OUT   = 13'b1000000000000
  } sxbl_state_e;

  sxbl_state_e state_q, state_d;
  // set once the query is done: the insert under way is the new prefix
  logic second_q, second_d;

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    cmd_o    = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.init_root = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          second_d     = 1'b0;
          state_d      = start_sequence_i ? ST_CLR : ST_PFX;
        end
      end
      ST_CLR: begin
        cmd_o.clear_seq = 1'b1;
        state_d         = ST_ICHK;
      end
      ST_ICHK: begin
        cmd_o.ins_begin = 1'b1;
        cmd_o.ins_fresh = !second_q;
        if (sts_i.ins_blocked) begin
          state_d = second_q ? ST_OUT : ST_PFX;
        end else if (second_q) begin
          state_d = ST_ILOAD;
        end else begin
          state_d = ST_IWALK;
        end
      end
      ST_ILOAD: begin
        cmd_o.ins_load = 1'b1;
        state_d        = sts_i.walk_done ? ST_IWB : ST_IWALK;
      end
      ST_IWALK: begin
        cmd_o.ins_walk = 1'b1;
        if (sts_i.ins_exists) begin
          state_d = ST_ILOAD;
        end else if (sts_i.lvl_zero) begin
          state_d = ST_IWB;
        end
      end
      ST_IWB: begin
        cmd_o.ins_wb = 1'b1;
        state_d      = second_q ? ST_OUT : ST_PFX;
      end
      ST_PFX: begin
        cmd_o.pfx = 1'b1;
        state_d   = ST_QBEG;
      end
      ST_QBEG: begin
        cmd_o.q_begin = 1'b1;
        state_d       = sts_i.limit_hi ? ST_TOT : ST_QCHK;
      end
      ST_QCHK: begin
        cmd_o.q_chk = 1'b1;
        if (sts_i.q_need_cnt) begin
          state_d = ST_QCNT;
        end else if (sts_i.qchk_stop) begin
          state_d = ST_TOT;
        end
      end
      ST_QCNT: begin
        cmd_o.q_cnt = 1'b1;
        state_d     = sts_i.qcnt_stop ? ST_TOT : ST_QCHK;
      end
      ST_TOT: begin
        cmd_o.tot = 1'b1;
        second_d  = 1'b1;
        state_d   = ST_ICHK;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

endmodule

@@ design/sxbl_dp.sv @@
// ----------------------------------------------------------------------------
// sxbl_dp
// trie node memory, node and walk registers, prefix, total and the result
// register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "subarray_xor_below_limit_counter_top_assert.svh"

module sxbl_dp
  import sxbl_pkg::*;
#(
  parameter int unsigned KEY_BITS   = 20,
  parameter int unsigned NODE_DEPTH = 32768,
  parameter int unsigned MAX_ITEMS  = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [LIMIT_W-1:0]   xor_limit_i,
  input  logic [ELEM_W-1:0]    element_value_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [CNT_OUT_W-1:0] ending_here_count_o,
  output logic [TOTAL_W-1:0]   running_total_o,
  output logic                 trie_full_o,
  input  sxbl_cmd_t            cmd_i,
  output sxbl_sts_t            sts_o
);

  localparam int unsigned PTR_W  = $clog2(NODE_DEPTH);
  localparam int unsigned USED_W = $clog2(NODE_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int unsigned LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned NODE_W = 2 * PTR_W + CNT_W;

  // node word: {child one, child zero, pass count}
  logic [NODE_W-1:0] mem [NODE_DEPTH];
  logic [NODE_W-1:0] rdata_q;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [NODE_W-1:0] mem_wdata;
  logic [PTR_W-1:0]  mem_raddr;

  logic [LIMIT_W-1:0]   limit_q;
  logic [KEY_BITS-1:0]  prefix_q;
  logic [TOTAL_W-1:0]   total_q;
  logic                 full_q;
  logic [CNT_W-1:0]     stored_q;
  logic [USED_W-1:0]    used_q;
  logic                 out_valid_q;

  logic [KEY_BITS-1:0]  elem_q;
  logic [LVL_W-1:0]     lvl_q;
  logic                 walk_done_q;
  logic [PTR_W-1:0]     node_c0_q;
  logic [PTR_W-1:0]     node_c1_q;
  logic [CNT_W-1:0]     node_cnt_q;
  logic [PTR_W-1:0]     idx_q;
  logic [PTR_W-1:0]     nxt_q;
  logic [CNT_W-1:0]     sum_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic [TOTAL_W-1:0]   out_total_q;
  logic                 out_full_q;

  logic [PTR_W-1:0]    rd_c0, rd_c1;
  logic [CNT_W-1:0]    rd_cnt;
  logic [KEY_BITS-1:0] limit_key;
  logic                limit_hi;
  logic                lvl_zero;
  logic                key_bit;
  logic                lim_bit;
  logic                ins_blocked;
  logic [PTR_W-1:0]    ins_nxt;
  logic                ins_exists;
  logic [PTR_W-1:0]    new_ptr;
  logic [PTR_W-1:0]    wr_c0, wr_c1;
  logic [PTR_W-1:0]    q_same, q_other, q_next;
  logic                q_need_cnt;
  logic [TOTAL_W:0]    total_sum;

  assign rd_c1  = rdata_q[NODE_W-1 -: PTR_W];
  assign rd_c0  = rdata_q[CNT_W +: PTR_W];
  assign rd_cnt = rdata_q[CNT_W-1:0];

  assign limit_key = KEY_BITS'(limit_q);
  // limit bits at or above the key width let every stored prefix through
  assign limit_hi  = |(limit_q >> KEY_BITS);
  assign lvl_zero  = (lvl_q == '0);
  assign key_bit   = prefix_q[lvl_q];
  assign lim_bit   = limit_key[lvl_q];

  assign ins_blocked = (stored_q >= CNT_W'(MAX_ITEMS)) ||
                       (used_q > USED_W'(NODE_DEPTH - KEY_BITS));
  assign ins_nxt    = key_bit ? node_c1_q : node_c0_q;
  assign ins_exists = |ins_nxt;
  assign new_ptr    = used_q[PTR_W-1:0];
  assign wr_c0      = (!key_bit && !ins_exists) ? new_ptr : node_c0_q;
  assign wr_c1      = (key_bit && !ins_exists) ? new_ptr : node_c1_q;

  assign q_same     = key_bit ? rd_c1 : rd_c0;
  assign q_other    = key_bit ? rd_c0 : rd_c1;
  assign q_next     = lim_bit ? q_other : q_same;
  assign q_need_cnt = lim_bit && (|q_same);

  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(sum_q);

  always_comb begin
    sts_o             = '0;
    sts_o.ins_blocked = ins_blocked;
    sts_o.ins_exists  = ins_exists;
    sts_o.walk_done   = walk_done_q;
    sts_o.lvl_zero    = lvl_zero;
    sts_o.limit_hi    = limit_hi;
    sts_o.q_need_cnt  = q_need_cnt;
    sts_o.qchk_stop   = (q_next == '0) || lvl_zero;
    sts_o.qcnt_stop   = (nxt_q == '0) || lvl_zero;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {node_c1_q, node_c0_q, node_cnt_q};
    mem_raddr = '0;
    if (cmd_i.init_root) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '0;
    end
    if (cmd_i.ins_walk) begin
      mem_we    = 1'b1;
      mem_wdata = {wr_c1, wr_c0, node_cnt_q};
      mem_raddr = ins_nxt;
    end
    if (cmd_i.ins_wb) begin
      mem_we = 1'b1;
    end
    if (cmd_i.q_chk) begin
      mem_raddr = q_need_cnt ? q_same : q_next;
    end
    if (cmd_i.q_cnt) begin
      mem_raddr = nxt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '0;
      prefix_q    <= '0;
      total_q     <= '0;
      full_q      <= 1'b0;
      stored_q    <= '0;
      used_q      <= USED_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= xor_limit_i;
      end
      if (cmd_i.clear_seq) begin
        prefix_q <= '0;
        total_q  <= '0;
        full_q   <= 1'b0;
        stored_q <= '0;
        used_q   <= USED_W'(1);
      end
      if (cmd_i.ins_begin) begin
        if (ins_blocked) begin
          full_q <= 1'b1;
        end else begin
          stored_q <= stored_q + CNT_W'(1);
        end
      end
      if (cmd_i.ins_walk && !ins_exists) begin
        used_q <= used_q + USED_W'(1);
      end
      if (cmd_i.pfx) begin
        prefix_q <= prefix_q ^ elem_q;
      end
      if (cmd_i.tot) begin
        total_q <= total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      elem_q <= KEY_BITS'(element_value_i);
    end
    if (cmd_i.ins_begin) begin
      lvl_q       <= LVL_W'(KEY_BITS - 1);
      idx_q       <= '0;
      walk_done_q <= 1'b0;
      if (cmd_i.ins_fresh) begin
        // a start builds on an empty root, no read needed
        node_c0_q  <= '0;
        node_c1_q  <= '0;
        node_cnt_q <= CNT_W'(1);
      end
    end
    if (cmd_i.ins_load) begin
      node_c0_q  <= rd_c0;
      node_c1_q  <= rd_c1;
      node_cnt_q <= rd_cnt + CNT_W'(1);
    end
    if (cmd_i.ins_walk) begin
      if (!lvl_zero) begin
        lvl_q <= lvl_q - LVL_W'(1);
      end
      if (ins_exists) begin
        idx_q       <= ins_nxt;
        walk_done_q <= lvl_zero;
      end else begin
        idx_q      <= new_ptr;
        node_c0_q  <= '0;
        node_c1_q  <= '0;
        node_cnt_q <= CNT_W'(1);
      end
    end
    if (cmd_i.q_begin) begin
      lvl_q <= LVL_W'(KEY_BITS - 1);
      sum_q <= limit_hi ? stored_q : '0;
    end
    if (cmd_i.q_chk) begin
      if (q_need_cnt) begin
        nxt_q <= q_other;
      end else if (!lvl_zero) begin
        lvl_q <= lvl_q - LVL_W'(1);
      end
    end
    if (cmd_i.q_cnt) begin
      sum_q <= sum_q + rd_cnt;
      if (!lvl_zero) begin
        lvl_q <= lvl_q - LVL_W'(1);
      end
    end
    if (cmd_i.load_out) begin
      out_cnt_q   <= CNT_OUT_W'(sum_q);
      out_total_q <= total_q;
      out_full_q  <= full_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign ending_here_count_o = out_cnt_q;
  assign running_total_o     = out_total_q;
  assign trie_full_o         = out_full_q;

  `SXBL_ASSERT_NOW(a_stored_cap, 1'b1, stored_q <= CNT_W'(MAX_ITEMS), "stored items over capacity")
  `SXBL_ASSERT_NOW(a_used_cap, 1'b1, used_q <= USED_W'(NODE_DEPTH), "node allocation over depth")
  `SXBL_ASSERT_NOW(a_no_overwrite, cmd_i.load_out, !out_valid_q || out_ready_i,
                   "result overwritten before taken")
  `SXBL_ASSERT_NEXT(a_alloc_step, cmd_i.ins_walk && !ins_exists && !cmd_i.clear_seq,
                    used_q != '0, "allocation pointer wrapped")

endmodule
